[sv/asws_pkg.sv]
// Package for the array stack with search: command and status codes,
// default depth, and the packed item types of both channels.
// Used by the top level, the checker and the testbench; depends on nothing.
package asws_pkg;

    // Default number of entries in the stack store.
    localparam int DEPTH_DEFAULT = 64;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Command codes.
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_SET    = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADPOS  = 3'd3;
    localparam logic [2:0] ST_NOMATCH = 3'd4;

    // One input item.
    typedef struct packed {
        logic        [2:0]        command;
        logic signed [WORD_W-1:0] value;
        logic        [6:0]        position;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        [2:0]        status;
        logic signed [WORD_W-1:0] data;
        logic        [6:0]        match_position;
        logic                     last;
    } t_out_item;

endpackage

[sv/array_stack_with_search_top.sv]
// Top level of the array stack with search: command decode, entry count,
// search scan sequencer and result register around one stack RAM.
// Depends on asws_pkg and asws_ram.
//
// Usage: an item (command, value, position) is accepted at a rising edge
// where start is high and busy is low. Every result is shown on o_result
// for exactly one cycle with o_strobe high; the receiver cannot stall, so
// results are never held back.
// Push, pop, peek, set and clear leave busy low, so a
// new item may follow in the next cycle. Their single result passes the
// RAM read and then the result register.
// Search on a stack of N entries reads one entry per cycle through the
// single RAM read port and holds busy high until the scan is flushed; its results
// (one per match, bottom first, the final one marked last, or one no-match
// result) pass the RAM read, the compare and the result register. Search on an empty stack
// answers like the other commands; unused command codes leave busy low
// and give no result.
// Reset empties the stack and drops any scan or pending result. The store
// itself is not cleared: only entries written by push or set are read.
module array_stack_with_search_top #(
    parameter int DEPTH = asws_pkg::DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  asws_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output asws_pkg::t_out_item  o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Entry count and first result stage.
    logic [CW-1:0] r_count;
    logic          r_s1_valid;
    logic [2:0]    r_s1_status;
    logic          r_s1_use_q;

    // Search scan state.
    logic                            r_scan;
    logic [CW-1:0]                   r_scan_addr;
    logic                            r_cmp_valid;
    logic [6:0]                      r_cmp_pos;
    logic                            r_cmp_final;
    logic signed [asws_pkg::WORD_W-1:0] r_key;
    logic                            r_pend_valid;
    logic [6:0]                      r_pend_pos;
    logic                            r_flush;

    // Result register.
    logic                 r_strobe;
    logic                 n_strobe;
    asws_pkg::t_out_item  r_out;
    asws_pkg::t_out_item  n_out;

    // RAM connections.
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [asws_pkg::WORD_W-1:0]  ram_q;

    logic          accept;
    logic          full;
    logic          empty;
    logic          pos_ok;
    logic          hit;
    logic [CW-1:0] cnt_m1;
    logic [6:0]    pos_m1;
    logic [CW-1:0] scan_next;

    assign accept    = start && !busy;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign pos_ok    = (i_item.position != 7'd0) && (i_item.position <= 7'(r_count));
    assign cnt_m1    = r_count - CW'(1);
    assign pos_m1    = i_item.position - 7'd1;
    assign scan_next = r_scan_addr + CW'(1);
    assign hit       = (ram_q == r_key);
    assign busy      = r_scan || r_cmp_valid || r_flush;

    // RAM address and write decode for the accepted item.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_raddr = r_scan_addr[AW-1:0];
        if (accept) begin
            unique case (i_item.command) inside
                asws_pkg::CMD_PUSH: begin
                    ram_we    = !full;
                    ram_waddr = r_count[AW-1:0];
                end
                asws_pkg::CMD_POP, asws_pkg::CMD_PEEK: begin
                    ram_raddr = cnt_m1[AW-1:0];
                end
                asws_pkg::CMD_SEARCH: begin
                    ram_raddr = '0;
                end
                asws_pkg::CMD_SET: begin
                    ram_we    = pos_ok;
                    ram_waddr = pos_m1[AW-1:0];
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    asws_ram #(
        .WIDTH (asws_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Command handling: count update and first result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= 1'b0;
            if (accept) begin
                unique case (i_item.command) inside
                    asws_pkg::CMD_PUSH: begin
                        r_s1_valid  <= 1'b1;
                        r_s1_use_q  <= 1'b0;
                        r_s1_status <= full ? asws_pkg::ST_FULL : asws_pkg::ST_OK;
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    asws_pkg::CMD_POP, asws_pkg::CMD_PEEK: begin
                        r_s1_valid  <= 1'b1;
                        r_s1_use_q  <= !empty;
                        r_s1_status <= empty ? asws_pkg::ST_EMPTY : asws_pkg::ST_OK;
                        if (!empty && i_item.command == asws_pkg::CMD_POP) begin
                            r_count <= cnt_m1;
                        end
                    end
                    asws_pkg::CMD_SEARCH: begin
                        // An empty stack answers at once; otherwise the scan answers.
                        r_s1_valid  <= empty;
                        r_s1_use_q  <= 1'b0;
                        r_s1_status <= asws_pkg::ST_NOMATCH;
                    end
                    asws_pkg::CMD_SET: begin
                        r_s1_valid  <= 1'b1;
                        r_s1_use_q  <= 1'b0;
                        r_s1_status <= pos_ok ? asws_pkg::ST_OK : asws_pkg::ST_BADPOS;
                    end
                    asws_pkg::CMD_CLEAR: begin
                        r_s1_valid  <= 1'b1;
                        r_s1_use_q  <= 1'b0;
                        r_s1_status <= asws_pkg::ST_OK;
                        r_count     <= '0;
                    end
                    default: begin
                        r_s1_valid <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Search scan: one read per cycle, compare in the cycle after each read, then flush.
    // A match is held as pending until the next match or the end of the scan
    // shows whether it is the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan       <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_flush      <= 1'b0;
        end else begin
            r_cmp_valid <= 1'b0;
            r_flush     <= 1'b0;
            if (accept && i_item.command == asws_pkg::CMD_SEARCH && !empty) begin
                r_key        <= i_item.value;
                r_cmp_valid  <= 1'b1;
                r_cmp_pos    <= 7'd1;
                r_cmp_final  <= (r_count == CW'(1));
                r_scan_addr  <= CW'(1);
                r_scan       <= (r_count != CW'(1));
                r_pend_valid <= 1'b0;
            end else if (r_scan) begin
                r_cmp_valid <= 1'b1;
                r_cmp_pos   <= 7'(r_scan_addr) + 7'd1;
                r_cmp_final <= (scan_next == r_count);
                r_scan_addr <= scan_next;
                r_scan      <= (scan_next != r_count);
            end
            if (r_cmp_valid) begin
                if (hit) begin
                    r_pend_valid <= 1'b1;
                    r_pend_pos   <= r_cmp_pos;
                end
                r_flush <= r_cmp_final;
            end
            if (r_flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Result selection: plain commands, a superseded match, or the scan end.
    always_comb begin
        n_strobe = 1'b0;
        n_out    = '0;
        if (r_s1_valid) begin
            n_strobe      = 1'b1;
            n_out.status  = r_s1_status;
            n_out.data    = r_s1_use_q ? ram_q : '0;
            n_out.last    = 1'b1;
        end else if (r_cmp_valid && hit && r_pend_valid) begin
            n_strobe             = 1'b1;
            n_out.status         = asws_pkg::ST_OK;
            n_out.match_position = r_pend_pos;
            n_out.last           = 1'b0;
        end else if (r_flush) begin
            n_strobe             = 1'b1;
            n_out.status         = r_pend_valid ? asws_pkg::ST_OK : asws_pkg::ST_NOMATCH;
            n_out.match_position = r_pend_valid ? r_pend_pos : 7'd0;
            n_out.last           = 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // The end of a scan always delivers a result marked last.
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |=> (o_strobe && o_result.last))
        else $error("scan end gave no final result");

    // An accepted push onto a stack with room grows the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.command == asws_pkg::CMD_PUSH && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the entry count");

    // The count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A no-match result is final and carries no position.
    a_nomatch_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == asws_pkg::ST_NOMATCH)
        |-> (o_result.last && o_result.match_position == 7'd0))
        else $error("malformed no-match result");

endmodule

[sv/asws_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. Depends on no package.
module asws_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/asws_checker.sv]
// Checker for the array stack with search: watches the command and result
// channels, predicts each result from its own copy of the stack, and compares.
// Depends on asws_pkg for the item types and the command and status codes.
module asws_checker #(
    parameter int DEPTH = asws_pkg::DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  asws_pkg::t_in_item   i_item,
    input  logic                 i_strobe,
    input  asws_pkg::t_out_item  i_result,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the stack and the results still owed by the block.
    logic [asws_pkg::WORD_W-1:0] stack_words [DEPTH];
    int                          stack_fill = 0;
    asws_pkg::t_out_item         owed_results [$];
    int                          fail_total = 0;

    // Append one result to the tail of the owed list.
    task automatic owe_result(input asws_pkg::t_out_item res);
        owed_results.insert(owed_results.size(), res);
    endtask

    // Apply one accepted item to the shadow stack and queue what it must return.
    task automatic apply_command(input asws_pkg::t_in_item item);
        asws_pkg::t_out_item res;
        int                  hits;
        int                  seen;
        res      = '0;
        res.last = 1'b1;
        hits     = 0;
        seen     = 0;
        case (item.command)
            asws_pkg::CMD_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    res.status = asws_pkg::ST_FULL;
                end else begin
                    stack_words[stack_fill] = item.value;
                    stack_fill++;
                    res.status = asws_pkg::ST_OK;
                end
                owe_result(res);
            end
            asws_pkg::CMD_POP, asws_pkg::CMD_PEEK: begin
                if (stack_fill == 0) begin
                    res.status = asws_pkg::ST_EMPTY;
                end else begin
                    res.status = asws_pkg::ST_OK;
                    res.data   = stack_words[stack_fill - 1];
                    if (item.command == asws_pkg::CMD_POP) begin
                        stack_fill--;
                    end
                end
                owe_result(res);
            end
            asws_pkg::CMD_SEARCH: begin
                // Count the matches first so the final one can carry the last mark.
                for (int i = 0; i < stack_fill; i++) begin
                    if (stack_words[i] == item.value) begin
                        hits++;
                    end
                end
                if (hits == 0) begin
                    res.status = asws_pkg::ST_NOMATCH;
                    owe_result(res);
                end else begin
                    for (int i = 0; i < stack_fill; i++) begin
                        if (stack_words[i] == item.value) begin
                            seen++;
                            res.status         = asws_pkg::ST_OK;
                            res.match_position = 7'(i + 1);
                            res.last           = (seen == hits);
                            owe_result(res);
                        end
                    end
                end
            end
            asws_pkg::CMD_SET: begin
                if (item.position == 0 || item.position > stack_fill ||
                    item.position > DEPTH) begin
                    res.status = asws_pkg::ST_BADPOS;
                end else begin
                    stack_words[item.position - 1] = item.value;
                    res.status = asws_pkg::ST_OK;
                end
                owe_result(res);
            end
            asws_pkg::CMD_CLEAR: begin
                stack_fill = 0;
                res.status = asws_pkg::ST_OK;
                owe_result(res);
            end
            default: begin
                // Unused codes leave the stack alone and return nothing.
            end
        endcase
    endtask

    // Compare each result with the oldest one owed, then take in a new item.
    always @(posedge i_clk) begin : watch
        asws_pkg::t_out_item want;
        if (!i_rst_n) begin
            stack_fill = 0;
            owed_results.delete();
        end else begin
            if (i_strobe) begin
                if (owed_results.size() == 0) begin
                    fail_total++;
                    $display("%t: unexpected result status %0d data %h pos %0d last %0b",
                             $realtime, i_result.status, i_result.data,
                             i_result.match_position, i_result.last);
                end else begin
                    want = owed_results.pop_front();
                    if (i_result !== want) begin
                        fail_total++;
                        $display("%t: result mismatch, expected status %0d data %h pos %0d last %0b",
                                 $realtime, want.status, want.data,
                                 want.match_position, want.last);
                        $display("%t: result mismatch, actual status %0d data %h pos %0d last %0b",
                                 $realtime, i_result.status, i_result.data,
                                 i_result.match_position, i_result.last);
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_command(i_item);
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/tb.sv]
// Testbench top for the array stack with search: clock, reset, directed and
// random command items with random gaps, and the final verdict.
// Depends on asws_pkg, array_stack_with_search_top and asws_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = asws_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 300000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    asws_pkg::t_in_item  i_item;
    logic                o_strobe;
    asws_pkg::t_out_item o_result;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int fill_level  = 0;
    bit steady_flow = 1'b0;

    // A few recurring keys so that searches find matches.
    logic [asws_pkg::WORD_W-1:0] key_pool [4] = '{32'h0000_0005, 32'hDEAD_BEEF,
                                                  32'h8000_0000, 32'h7FFF_FFFF};

    always #6 i_clk = ~i_clk;

    array_stack_with_search_top #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    asws_checker #(
        .DEPTH(STACK_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item, after a random gap unless in steady flow, and hold it until the block takes it.
    task automatic send_item(input logic [2:0] cmd,
                             input logic [asws_pkg::WORD_W-1:0] value,
                             input logic [6:0] pos);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_item.command  <= cmd;
        i_item.value    <= value;
        i_item.position <= pos;
        do @(posedge i_clk); while (busy);
        // Track the fill level only to shape later stimulus.
        case (cmd)
            asws_pkg::CMD_PUSH:  if (fill_level < STACK_DEPTH) fill_level++;
            asws_pkg::CMD_POP:   if (fill_level > 0) fill_level--;
            asws_pkg::CMD_CLEAR: fill_level = 0;
            default: ;
        endcase
    endtask

    // Stop sending and wait until every owed result has come out.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Half recurring keys, some extremes, the rest fully random words.
    function automatic logic [asws_pkg::WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return key_pool[$urandom_range(0, 3)];
        if (r < 55) return 32'h8000_0000;
        if (r < 60) return 32'h7FFF_FFFF;
        if (r < 63) return 32'h0;
        if (r < 66) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // One random item; returns 0 for unused codes so they are not counted.
    task automatic random_item(input int push_pct, input int pop_pct, output bit counted);
        int         r;
        int         base;
        logic [2:0] cmd;
        logic [6:0] pos;
        r       = $urandom_range(0, 99);
        base    = push_pct + pop_pct;
        counted = 1'b1;
        pos     = 7'($urandom_range(0, 127));
        if (r < push_pct)       cmd = asws_pkg::CMD_PUSH;
        else if (r < base)      cmd = asws_pkg::CMD_POP;
        else if (r < base + 10) cmd = asws_pkg::CMD_PEEK;
        else if (r < base + 25) cmd = asws_pkg::CMD_SEARCH;
        else if (r < base + 40) cmd = asws_pkg::CMD_SET;
        else if (r < base + 42) cmd = asws_pkg::CMD_CLEAR;
        else begin
            cmd     = 3'($urandom_range(6, 7));
            counted = 1'b0;
        end
        // Most sets land on a filled position.
        if (cmd == asws_pkg::CMD_SET && fill_level > 0 && $urandom_range(0, 99) < 80) begin
            pos = 7'($urandom_range(1, fill_level));
        end
        send_item(cmd, pick_value(), pos);
    endtask

    // Random phase of a given command mix, with stretches of back-to-back items.
    task automatic random_phase(input int count, input int push_pct, input int pop_pct);
        int done;
        bit counted;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 29) == 0) steady_flow = ~steady_flow;
            random_item(push_pct, pop_pct, counted);
            if (counted) done++;
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty stack corner cases.
        send_item(asws_pkg::CMD_POP, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_PEEK, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_SEARCH, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_SET, 32'h1234_5678, 7'd0);
        send_item(asws_pkg::CMD_SET, 32'h1234_5678, 7'd1);

        // Extreme words, then peek, search hit and miss, sets good and bad, a search, pop, unused codes and clear.
        send_item(asws_pkg::CMD_PUSH, 32'h7FFF_FFFF, 7'd0);
        send_item(asws_pkg::CMD_PUSH, 32'h8000_0000, 7'd127);
        send_item(asws_pkg::CMD_PUSH, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_PUSH, 32'hFFFF_FFFF, 7'd64);
        send_item(asws_pkg::CMD_PEEK, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 7'd0);
        send_item(asws_pkg::CMD_SEARCH, 32'h1357_9BDF, 7'd0);
        send_item(asws_pkg::CMD_SET, 32'hAAAA_AAAA, 7'd0);
        send_item(asws_pkg::CMD_SET, 32'hAAAA_AAAA, 7'd5);
        send_item(asws_pkg::CMD_SET, 32'h7FFF_FFFF, 7'd4);
        send_item(asws_pkg::CMD_SET, 32'h5555_5555, 7'd1);
        send_item(asws_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 7'd0);
        send_item(asws_pkg::CMD_POP, 32'h0, 7'd0);
        send_item(3'd6, 32'hFFFF_FFFF, 7'd127);
        send_item(3'd7, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_CLEAR, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_POP, 32'h0, 7'd0);
        drain_results();

        // Fill to the top with one key so a search returns a match per entry.
        steady_flow = 1'b1;
        repeat (STACK_DEPTH) send_item(asws_pkg::CMD_PUSH, key_pool[1], 7'd0);
        steady_flow = 1'b0;
        send_item(asws_pkg::CMD_PUSH, 32'h1, 7'd0);
        send_item(asws_pkg::CMD_SEARCH, key_pool[1], 7'd0);
        send_item(asws_pkg::CMD_SET, 32'h8000_0000, 7'(STACK_DEPTH));
        send_item(asws_pkg::CMD_SET, 32'h8000_0000, 7'(STACK_DEPTH + 1));
        send_item(asws_pkg::CMD_SET, 32'h8000_0000, 7'd127);
        send_item(asws_pkg::CMD_PEEK, 32'h0, 7'd0);
        send_item(asws_pkg::CMD_SEARCH, 32'h8000_0000, 7'd0);
        send_item(asws_pkg::CMD_CLEAR, 32'h0, 7'd0);
        drain_results();

        // Random phases: balanced, push heavy to reach full, pop heavy to drain.
        random_phase(60, 36, 20);
        drain_results();
        random_phase(45, 50, 6);
        drain_results();
        random_phase(30, 16, 40);
        drain_results();

        if (fail_count == 0 && pending_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
